// File: src/nnt_pkg.sv
// Package with constants, tables and types of the nearest-note tuner.
package nnt_pkg;

  localparam int unsigned CLOCK_HZ_DEF      = 4197000;
  localparam int unsigned HISTORY_DEPTH_DEF = 10;
  localparam int unsigned OCTAVE_COUNT_DEF  = 3;
  localparam int unsigned NOTE_COUNT        = 12;
  localparam int unsigned BAR_MAX           = 7;
  localparam logic [28:0] FREQ_SAT          = 29'h1FFF_FFFF;

  localparam logic [1:0] REG_STABILITY = 2'd0;
  localparam logic [1:0] REG_CHANGE    = 2'd1;
  localparam logic [1:0] REG_MATCH     = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DEV,
    ST_HIST,
    ST_DIV,
    ST_DONE
  } state_t;

  function automatic logic [15:0] note_centihz(input logic [3:0] n);
    logic [15:0] r;
    unique case (n)
      4'd0:    r = 16'd6541;
      4'd1:    r = 16'd6930;
      4'd2:    r = 16'd7342;
      4'd3:    r = 16'd7778;
      4'd4:    r = 16'd8241;
      4'd5:    r = 16'd8731;
      4'd6:    r = 16'd9250;
      4'd7:    r = 16'd9800;
      4'd8:    r = 16'd10383;
      4'd9:    r = 16'd11000;
      4'd10:   r = 16'd11654;
      default: r = 16'd12347;
    endcase
    return r;
  endfunction

  function automatic logic [32:0] bar_thresh(input logic [2:0] k);
    logic [32:0] r;
    unique case (k)
      3'd0:    r = 33'd4303836693;
      3'd1:    r = 33'd4321630472;
      3'd2:    r = 33'd4339497818;
      3'd3:    r = 33'd4357439034;
      3'd4:    r = 33'd4375454426;
      3'd5:    r = 33'd4393544302;
      default: r = 33'd4411708968;
    endcase
    return r;
  endfunction

endpackage

// File: src/nnt_if.sv
// Valid/ready channel interfaces of the tuner.
interface nnt_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] period_count;
  modport source (output valid, output period_count, input ready);
  modport sink (input valid, input period_count, output ready);
  modport monitor (input valid, input period_count, input ready);
endinterface

interface nnt_out_if;
  logic              valid;
  logic              ready;
  logic [3:0]        note_index;
  logic [1:0]        octave;
  logic signed [3:0] deviation;
  logic              stable;
  logic              report_valid;
  logic [28:0]       frequency_centihz;
  modport source (output valid, output note_index, output octave, output deviation,
                  output stable, output report_valid, output frequency_centihz,
                  input ready);
  modport sink (input valid, input note_index, input octave, input deviation,
                input stable, input report_valid, input frequency_centihz,
                output ready);
  modport monitor (input valid, input note_index, input octave, input deviation,
                   input stable, input report_valid, input frequency_centihz,
                   input ready);
endinterface

interface nnt_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
  modport monitor (input valid, input index, input data, input ready);
endinterface

// File: src/nnt_divider.sv
// Restoring divider, one quotient bit per cycle.
module nnt_divider #(
  parameter int unsigned NUM_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [15:0]      denom,
  output logic             done,
  output logic [NUM_W-1:0] quot
);
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_sh;
  logic [15:0]      rem;
  logic [15:0]      den;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [16:0]      trial;

  assign trial = {rem, num_sh[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        num_sh <= numer;
        den    <= denom;
        rem    <= '0;
        cnt    <= CNT_W'(NUM_W);
      end else if (busy) begin
        num_sh <= {num_sh[NUM_W-2:0], 1'b0};
        if (trial >= {1'b0, den}) begin
          rem  <= 16'(trial - {1'b0, den});
          quot <= {quot[NUM_W-2:0], 1'b1};
        end else begin
          rem  <= trial[15:0];
          quot <= {quot[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: src/nearest_note_tuner.sv
// Top level of the nearest-note tuner.
//   channel  role    payload
//   in_ch    sink    period_count
//   out_ch   source  note_index, octave, deviation, stable, report_valid, frequency
//   cfg_ch   sink    index, data
// One item goes from acceptance to the next ready through a table search one entry a
// cycle, one reference load and seven bar compares, a history walk one pair a cycle, a
// 32-step divide, a result held until it is taken and a return to idle. The walk ends
// early and the divide is skipped when the history is unsteady; the divide is also
// skipped when the count is zero. Reset is synchronous and restores the state, limits,
// held note and an empty history. The input is not ready until the result is taken.
module nearest_note_tuner #(
  parameter int unsigned CLOCK_HZ      = nnt_pkg::CLOCK_HZ_DEF,
  parameter int unsigned HISTORY_DEPTH = nnt_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned OCTAVE_COUNT  = nnt_pkg::OCTAVE_COUNT_DEF
) (
  input logic clk,
  input logic rst,
  nnt_in_if.sink    in_ch,
  nnt_out_if.source out_ch,
  nnt_cfg_if.sink   cfg_ch
);
  localparam int unsigned ENTRIES = nnt_pkg::NOTE_COUNT * OCTAVE_COUNT;
  localparam int unsigned E_W     = $clog2(ENTRIES + 1);
  localparam int unsigned H_W     = $clog2(HISTORY_DEPTH);
  localparam logic [31:0] NUMER   = 32'(64'(CLOCK_HZ) * 100);
  localparam logic [28:0] FREQ_SAT_L = nnt_pkg::FREQ_SAT;

  logic [31:0] ref_tab [ENTRIES];
  for (genvar o = 0; o < OCTAVE_COUNT; o++) begin : g_oct
    for (genvar n = 0; n < nnt_pkg::NOTE_COUNT; n++) begin : g_note
      localparam logic [31:0] REF_P =
        32'((64'(CLOCK_HZ) * 100) / (64'(nnt_pkg::note_centihz(4'(n))) << o));
      assign ref_tab[o * nnt_pkg::NOTE_COUNT + n] = REF_P;
    end
  end

  nnt_pkg::state_t state, state_next;
  logic [15:0] stability_limit, change_limit, match_limit;
  logic [15:0] period_history [HISTORY_DEPTH];
  logic [H_W-1:0] history_pointer;
  logic [3:0]  held_note;
  logic [1:0]  held_octave;
  logic [28:0] last_reported_freq;
  logic [15:0] count;
  logic [31:0] best;
  logic [E_W-1:0] idx;
  logic [3:0]  ni;
  logic [1:0]  oi;
  logic        refp_ok;
  logic [31:0] refp;
  logic [2:0]  k;
  logic signed [3:0] dev;
  logic        stable;
  logic [H_W-1:0] hidx;
  logic        rep;
  logic [28:0] freq;
  logic        div_start, div_done;
  logic [31:0] quot;

  logic [31:0] cur_ref, delta;
  logic [51:0] lhs_up, rhs_up, lhs_dn, rhs_dn;
  logic [16:0] hdiff;
  logic [32:0] f_round;
  logic [28:0] f_sat, fdiff;

  assign cur_ref = ref_tab[idx[E_W-1:0] < E_W'(ENTRIES) ? idx : '0];
  assign delta   = cur_ref > {16'd0, count} ? cur_ref - {16'd0, count}
                                             : {16'd0, count} - cur_ref;
  assign lhs_up  = {refp[19:0], 32'd0};
  assign rhs_up  = 52'(count) * 52'(nnt_pkg::bar_thresh(k));
  assign lhs_dn  = {4'd0, count, 32'd0};
  assign rhs_dn  = 52'(refp[19:0]) * 52'(nnt_pkg::bar_thresh(k));
  assign hdiff   = period_history[hidx] > period_history[hidx - 1'b1]
                 ? 17'(period_history[hidx]) - 17'(period_history[hidx - 1'b1])
                 : 17'(period_history[hidx - 1'b1]) - 17'(period_history[hidx]);
  assign f_round = 33'(quot);
  assign f_sat   = f_round > 33'(FREQ_SAT_L) ? FREQ_SAT_L : f_round[28:0];
  assign fdiff   = f_sat > last_reported_freq ? f_sat - last_reported_freq
                                              : last_reported_freq - f_sat;

  nnt_divider #(.NUM_W(32)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .numer(NUMER + 32'(count >> 1)), .denom(count),
    .done(div_done), .quot(quot)
  );

  assign in_ch.ready  = (state == nnt_pkg::ST_IDLE);
  assign cfg_ch.ready = (state == nnt_pkg::ST_IDLE);
  assign out_ch.valid = (state == nnt_pkg::ST_DONE);
  assign out_ch.note_index = held_note;
  assign out_ch.octave = held_octave;
  assign out_ch.deviation = dev;
  assign out_ch.stable = stable;
  assign out_ch.report_valid = rep;
  assign out_ch.frequency_centihz = freq;

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    unique case (state)
      nnt_pkg::ST_IDLE:   if (in_ch.valid) state_next = nnt_pkg::ST_SEARCH;
      nnt_pkg::ST_SEARCH: if (idx == E_W'(ENTRIES - 1)) state_next = nnt_pkg::ST_DEV;
      nnt_pkg::ST_DEV:    if (k == 3'(nnt_pkg::BAR_MAX - 1)) state_next = nnt_pkg::ST_HIST;
      nnt_pkg::ST_HIST: begin
        if (hdiff > 17'(stability_limit)) begin
          state_next = nnt_pkg::ST_DONE;
        end else if (hidx == H_W'(HISTORY_DEPTH - 1)) begin
          if (count != 16'd0) begin
            state_next = nnt_pkg::ST_DIV;
            div_start = 1'b1;
          end else begin
            state_next = nnt_pkg::ST_DONE;
          end
        end
      end
      nnt_pkg::ST_DIV:    if (div_done) state_next = nnt_pkg::ST_DONE;
      nnt_pkg::ST_DONE:   if (out_ch.ready) state_next = nnt_pkg::ST_IDLE;
      default:            state_next = nnt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nnt_pkg::ST_IDLE;
      stability_limit <= 16'd1000;
      change_limit <= 16'd10;
      match_limit <= 16'd65000;
      for (int i = 0; i < HISTORY_DEPTH; i++) period_history[i] <= '0;
      history_pointer <= '0;
      held_note <= '0;
      held_octave <= '0;
      last_reported_freq <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        nnt_pkg::ST_IDLE: begin
          if (cfg_ch.valid) begin
            unique case (cfg_ch.index)
              nnt_pkg::REG_STABILITY: stability_limit <= cfg_ch.data;
              nnt_pkg::REG_CHANGE:    change_limit <= cfg_ch.data;
              nnt_pkg::REG_MATCH:     match_limit <= cfg_ch.data;
              default: ;
            endcase
          end
          if (in_ch.valid) begin
            count <= in_ch.period_count;
            best <= {16'd0, match_limit};
            idx <= '0;
            ni <= '0;
            oi <= '0;
            refp_ok <= 1'b0;
          end
        end
        nnt_pkg::ST_SEARCH: begin
          if (delta < best) begin
            best <= delta;
            held_note <= ni;
            held_octave <= oi;
          end
          idx <= idx + 1'b1;
          if (ni == 4'(nnt_pkg::NOTE_COUNT - 1)) begin
            ni <= '0;
            oi <= oi + 1'b1;
          end else begin
            ni <= ni + 1'b1;
          end
          if (idx == E_W'(ENTRIES - 1)) begin
            k <= '0;
            dev <= '0;
          end
        end
        nnt_pkg::ST_DEV: begin
          if (!refp_ok) begin
            refp <= ref_tab[E_W'(held_octave) * E_W'(nnt_pkg::NOTE_COUNT) + E_W'(held_note)];
            refp_ok <= 1'b1;
          end else begin
            if (lhs_up >= rhs_up) dev <= 4'(k) + 4'sd1;
            else if (lhs_dn >= rhs_dn) dev <= -(4'(k) + 4'sd1);
            k <= k + 1'b1;
          end
          if (k == 3'(nnt_pkg::BAR_MAX - 1)) begin
            period_history[history_pointer] <= count;
            history_pointer <= history_pointer == H_W'(HISTORY_DEPTH - 1)
                             ? '0 : history_pointer + 1'b1;
            hidx <= H_W'(1);
            stable <= 1'b1;
            rep <= 1'b0;
            freq <= '0;
          end
        end
        nnt_pkg::ST_HIST: begin
          if (hdiff > 17'(stability_limit)) stable <= 1'b0;
          if (hidx != H_W'(HISTORY_DEPTH - 1)) hidx <= hidx + 1'b1;
        end
        nnt_pkg::ST_DIV: begin
          if (div_done && fdiff > 29'(change_limit)) begin
            rep <= 1'b1;
            freq <= f_sat;
            last_reported_freq <= f_sat;
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_ch.valid |-> !in_ch.ready)
    else $error("input ready while a result waits");
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.frequency_centihz))
    else $error("result changed under stall");
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.report_valid || out_ch.frequency_centihz == '0)
    else $error("frequency without report");
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.report_valid |-> out_ch.stable)
    else $error("report while unstable");
endmodule
